[sv/gwc_pkg.sv]
package gwc_pkg;

    // fixed field widths
    localparam int unsigned CFG_W     = 7;
    localparam int unsigned PIX_W     = 8;
    localparam int unsigned COORD_W   = 6;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 16;

    // configuration register indexes
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    // accumulator control from the sequencer
    typedef struct packed {
        logic pix_en;   // pixel transfer this cycle
        logic clear;    // drop sums and counters, start a new window
    } t_acc_ctl;

    // divider status to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[sv/gray_weighted_centroid_core.sv]
// channel  | dir | payload                                   | transfer when
// s_axis   | in  | tdata[7:0] pixel                          | i_s_tvalid & o_s_tready
// m_axis   | out | tdata[5:0] center_x, [11:6] center_y;     | o_m_tvalid & i_m_tready
//          |     | tuser empty_res                           |
// cfg      | in  | index 0 window_width, 1 window_height     | i_cfg_valid & o_cfg_ready
//
// pixels are taken one per cycle while the core is idle; the last pixel of a window
// starts a shared restoring divider that runs twice (column, then row); each run
// has a launch step, a bit step for each quotient bit, a rounding step and a done
// step, and a final load step moves the result into the output register;
// an all-zero window skips the divider and goes straight to the load step
// s_tready is low from the last pixel until the result enters the output register
// the output register lets the next window stream in while a result waits
// reset (i_rst_n low, synchronous) clears sums, counters, output valid and sets 64x64
module gray_weighted_centroid_core
    import gwc_pkg::*;
#(
    parameter int unsigned MAX_SIDE = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // [7:0] pixel
    // result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // [5:0] center_x, [11:6] center_y, zero pad
    output logic                 o_m_tuser,   // [0] empty_res
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int unsigned CW   = $clog2(MAX_SIDE);
    localparam int unsigned PS_W = PIX_W + 2 * CW;
    localparam int unsigned WS_W = PIX_W + 3 * CW;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_LAUNCHX = 6'b000010,
        S_WAITX   = 6'b000100,
        S_LAUNCHY = 6'b001000,
        S_WAITY   = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_width;
    logic [CFG_W-1:0]    r_height;
    logic [COORD_W-1:0]  r_qx;
    logic [COORD_W-1:0]  r_qy;
    logic                r_empty;
    logic                r_out_valid;
    logic [COORD_W-1:0]  r_out_x;
    logic [COORD_W-1:0]  r_out_y;
    logic                r_out_empty;
    t_acc_ctl            acc_ctl;
    t_div_stat           div_stat;
    logic                acc_last;
    logic [PS_W-1:0]     pix_sum;
    logic [WS_W-1:0]     col_sum;
    logic [WS_W-1:0]     row_sum;
    logic                div_start;
    logic [WS_W-1:0]     div_num;
    logic [CW-1:0]       div_quo;
    logic                pix_xfer;
    logic                load_out;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(64);
            r_height <= CFG_W'(64);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX_WIDTH:  r_width  <= i_cfg_data;
                CFG_IDX_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshakes
    assign o_s_tready = (r_state == S_IDLE);
    assign pix_xfer   = i_s_tvalid && o_s_tready;
    assign load_out   = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    assign acc_ctl.pix_en = pix_xfer;
    assign acc_ctl.clear  = load_out;

    gwc_accum #(
        .MAX_SIDE (MAX_SIDE)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (acc_ctl),
        .i_pixel   (i_s_tdata[PIX_W-1:0]),
        .i_width   (r_width),
        .i_height  (r_height),
        .o_last    (acc_last),
        .o_pix_sum (pix_sum),
        .o_col_sum (col_sum),
        .o_row_sum (row_sum)
    );

    // divider launches
    assign div_start = ((r_state == S_LAUNCHX) && (pix_sum != '0))
                    || (r_state == S_LAUNCHY);
    assign div_num   = (r_state == S_LAUNCHY) ? row_sum : col_sum;

    gwc_div #(
        .MAX_SIDE (MAX_SIDE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (pix_sum),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (pix_xfer && acc_last) n_state = S_LAUNCHX;
            S_LAUNCHX: n_state = (pix_sum == '0) ? S_DONE : S_WAITX;
            S_WAITX:   if (div_stat.done) n_state = S_LAUNCHY;
            S_LAUNCHY: n_state = S_WAITY;
            S_WAITY:   if (div_stat.done) n_state = S_DONE;
            S_DONE:    if (load_out) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // quotient capture
    always_ff @(posedge i_clk) begin
        if (r_state == S_LAUNCHX) begin
            r_empty <= (pix_sum == '0);
            r_qx    <= '0;
            r_qy    <= '0;
        end else if ((r_state == S_WAITX) && div_stat.done) begin
            r_qx <= COORD_W'(div_quo);
        end else if ((r_state == S_WAITY) && div_stat.done) begin
            r_qy <= COORD_W'(div_quo);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_x     <= r_qx;
            r_out_y     <= r_qy;
            r_out_empty <= r_empty;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_TDATA_W - 2 * COORD_W)'(0), r_out_y, r_out_x};
    assign o_m_tuser  = r_out_empty;

    // the divider is only launched while idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider launched while busy");

    // sums start from zero after a result is loaded
    a_clear_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (pix_sum == '0) && (col_sum == '0) && (row_sum == '0))
        else $error("accumulators not cleared after result");

    // an empty window carries zero coordinates
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |-> (r_out_x == '0) && (r_out_y == '0))
        else $error("empty window with nonzero coordinates");

endmodule

[sv/gwc_accum.sv]
module gwc_accum
    import gwc_pkg::*;
#(
    parameter int unsigned MAX_SIDE = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_acc_ctl                            i_ctl,
    input  logic [PIX_W-1:0]                    i_pixel,
    input  logic [CFG_W-1:0]                    i_width,
    input  logic [CFG_W-1:0]                    i_height,
    output logic                                o_last,
    output logic [PIX_W+2*$clog2(MAX_SIDE)-1:0] o_pix_sum,
    output logic [PIX_W+3*$clog2(MAX_SIDE)-1:0] o_col_sum,
    output logic [PIX_W+3*$clog2(MAX_SIDE)-1:0] o_row_sum
);

    localparam int unsigned CW     = $clog2(MAX_SIDE);
    localparam int unsigned PS_W   = PIX_W + 2 * CW;
    localparam int unsigned WS_W   = PIX_W + 3 * CW;
    localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int unsigned CMP_W  = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;

    logic [CW-1:0]    r_col, n_col;
    logic [CW-1:0]    r_row, n_row;
    logic [PS_W-1:0]  r_pix_sum;
    logic [WS_W-1:0]  r_col_sum;
    logic [WS_W-1:0]  r_row_sum;
    logic [CMP_W-1:0] w_eff, h_eff;
    logic [CMP_W-1:0] col_inc, row_inc;
    logic             row_end;

    // clamp a side register to 1..MAX_SIDE
    function automatic logic [CMP_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] ve;
        ve = CMP_W'(v);
        if (ve == '0) begin
            return CMP_W'(1);
        end else if (ve > CMP_W'(MAX_SIDE)) begin
            return CMP_W'(MAX_SIDE);
        end
        return ve;
    endfunction

    // row and window end detection
    always_comb begin
        w_eff   = clamp_side(i_width);
        h_eff   = clamp_side(i_height);
        col_inc = CMP_W'(r_col) + CMP_W'(1);
        row_inc = CMP_W'(r_row) + CMP_W'(1);
        row_end = (col_inc >= w_eff);
        o_last  = row_end && (row_inc >= h_eff);
        n_col   = row_end ? '0 : CW'(col_inc);
        n_row   = row_end ? CW'(row_inc) : r_row;
    end

    // sums and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_col     <= '0;
            r_row     <= '0;
            r_pix_sum <= '0;
            r_col_sum <= '0;
            r_row_sum <= '0;
        end else if (i_ctl.pix_en) begin
            r_pix_sum <= r_pix_sum + PS_W'(i_pixel);
            r_col_sum <= r_col_sum + WS_W'(i_pixel) * WS_W'(r_col);
            r_row_sum <= r_row_sum + WS_W'(i_pixel) * WS_W'(r_row);
            r_col     <= n_col;
            // the last pixel holds the row count until the window is cleared
            if (!o_last) begin
                r_row <= n_row;
            end
        end
    end

    assign o_pix_sum = r_pix_sum;
    assign o_col_sum = r_col_sum;
    assign o_row_sum = r_row_sum;

endmodule

[sv/gwc_div.sv]
module gwc_div
    import gwc_pkg::*;
#(
    parameter int unsigned MAX_SIDE = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [PIX_W+3*$clog2(MAX_SIDE)-1:0] i_num,
    input  logic [PIX_W+2*$clog2(MAX_SIDE)-1:0] i_den,
    output t_div_stat                           o_stat,
    output logic [$clog2(MAX_SIDE)-1:0]         o_quo
);

    localparam int unsigned CW    = $clog2(MAX_SIDE);
    localparam int unsigned PS_W  = PIX_W + 2 * CW;
    localparam int unsigned WS_W  = PIX_W + 3 * CW;
    localparam int unsigned CNT_W = $clog2(CW + 1);

    logic             r_run;
    logic             r_round;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WS_W-1:0]  r_rem;
    logic [WS_W-1:0]  r_dsh;
    logic [PS_W-1:0]  r_den;
    logic [CW-1:0]    r_quo;
    logic             ge;
    logic [PS_W:0]    twice;
    logic             up;

    // one quotient bit per cycle, then round to nearest, ties to even
    always_comb begin
        ge    = (r_rem >= r_dsh);
        twice = {r_rem[PS_W-1:0], 1'b0};
        up    = (twice > {1'b0, r_den}) || ((twice == {1'b0, r_den}) && r_quo[0]);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_round <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= r_round;
            if (i_start && !r_run && !r_round) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(CW);
            end else if (r_run) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_run   <= 1'b0;
                    r_round <= 1'b1;
                end
            end else begin
                r_round <= 1'b0;
            end
        end
    end

    // datapath: remainder, shifted divisor, quotient
    always_ff @(posedge i_clk) begin
        if (i_start && !r_run && !r_round) begin
            r_rem <= i_num;
            r_dsh <= WS_W'(i_den) << (CW - 1);
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_run) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_quo <= CW'({r_quo, ge});
        end else if (r_round) begin
            r_quo <= r_quo + CW'(up);
        end
    end

    assign o_stat.busy = r_run || r_round;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

    // the remainder is below the divisor once all bits are out
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round |-> (r_rem < WS_W'(r_den)))
        else $error("divider remainder not below divisor");

endmodule

[sim/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gwc_pkg::*;

    localparam int SIDE_MAX     = 64;
    localparam int RANDOM_ITEMS = 750;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLDOFF_LEN  = 300;

    // pixel content styles for stimulus
    typedef enum int {
        PIX_ZERO,
        PIX_SAT,
        PIX_LOW,
        PIX_SPARSE,
        PIX_FULL
    } t_pix_mode;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic               empty_res;
    } t_centroid;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_index = CFG_IDX_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    // window model state
    logic [CFG_W-1:0] width_reg  = 7'd64;
    logic [CFG_W-1:0] height_reg = 7'd64;
    logic [19:0]      intensity_sum = '0;
    logic [25:0]      col_moment    = '0;
    logic [25:0]      row_moment    = '0;
    logic [5:0]       col_idx       = '0;
    logic [5:0]       row_idx       = '0;

    logic [PIX_W-1:0] pixel_q[$];
    t_centroid        centroid_q[$];
    t_centroid        want;

    int error_cnt    = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    bit sender_steady = 1'b0;
    int press_req    = 0;
    int press_ack    = 0;
    int holdoff_left = 0;
    int ready_phase  = 0;
    logic [31:0] ready_bits = '1;

    gray_weighted_centroid_core #(
        .MAX_SIDE(SIDE_MAX)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // register value to usable side length
    function automatic int side_of(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > SIDE_MAX)
            return SIDE_MAX;
        return int'(v);
    endfunction

    // quotient rounded to nearest, ties to even
    function automatic logic [25:0] round_half_even(input logic [25:0] num,
                                                    input logic [19:0] den);
        logic [25:0] q;
        logic [25:0] r;
        logic [26:0] twice;
        q     = num / den;
        r     = num % den;
        twice = {r, 1'b0};
        if (twice > den || (twice == den && q[0]))
            q = q + 1'b1;
        return q;
    endfunction

    // fold one pixel into the window, queue the centroid on the last one
    task automatic accumulate_pixel(input logic [PIX_W-1:0] pix);
        int        w;
        int        h;
        t_centroid res;
        w = side_of(width_reg);
        h = side_of(height_reg);
        intensity_sum = intensity_sum + pix;
        col_moment    = col_moment + 26'(pix) * 26'(col_idx);
        row_moment    = row_moment + 26'(pix) * 26'(row_idx);
        if (int'(col_idx) + 1 < w) begin
            col_idx = col_idx + 1'b1;
        end else begin
            col_idx = '0;
            if (int'(row_idx) + 1 < h) begin
                row_idx = row_idx + 1'b1;
            end else begin
                if (intensity_sum == 0) begin
                    res.center_x  = '0;
                    res.center_y  = '0;
                    res.empty_res = 1'b1;
                end else begin
                    res.center_x  = COORD_W'(round_half_even(col_moment, intensity_sum));
                    res.center_y  = COORD_W'(round_half_even(row_moment, intensity_sum));
                    res.empty_res = 1'b0;
                end
                centroid_q = {centroid_q, res};
                intensity_sum = '0;
                col_moment    = '0;
                row_moment    = '0;
                row_idx       = '0;
            end
        end
    endtask

    // pixel driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                accumulate_pixel(i_s_tdata);
            if (!(i_s_tvalid && !o_s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= pixel_q.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        if (sender_steady)
                            gap_left = 0;
                        else if ($urandom_range(0, 3) == 0)
                            gap_left = $urandom_range(4, 12);
                        else
                            gap_left = $urandom_range(0, 2);
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (centroid_q.size() == 0) begin
                    $display("%0t: result transfer with none expected: tdata %h tuser %b",
                             $time, o_m_tdata, o_m_tuser);
                    error_cnt++;
                end else begin
                    want = centroid_q.pop_front();
                    if (o_m_tdata[COORD_W-1:0] !== want.center_x) begin
                        $display("%0t: center_x expected %0d actual %0d",
                                 $time, want.center_x, o_m_tdata[COORD_W-1:0]);
                        error_cnt++;
                    end
                    if (o_m_tdata[2*COORD_W-1:COORD_W] !== want.center_y) begin
                        $display("%0t: center_y expected %0d actual %0d",
                                 $time, want.center_y, o_m_tdata[2*COORD_W-1:COORD_W]);
                        error_cnt++;
                    end
                    if (o_m_tuser !== want.empty_res) begin
                        $display("%0t: empty_res expected %b actual %b",
                                 $time, want.empty_res, o_m_tuser);
                        error_cnt++;
                    end
                    if (o_m_tdata[M_TDATA_W-1:2*COORD_W] !== '0) begin
                        $display("%0t: tdata pad expected 0 actual %h",
                                 $time, o_m_tdata[M_TDATA_W-1:2*COORD_W]);
                        error_cnt++;
                    end
                end
            end
            // long hold-off on request
            if (press_ack != press_req) begin
                press_ack    = press_req;
                holdoff_left = HOLDOFF_LEN;
            end
            if (holdoff_left > 0)
                holdoff_left--;
            ready_phase = (ready_phase + 1) % 32;
            if (ready_phase == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_bits = '1;
                    1: ready_bits = $urandom;
                    2: ready_bits = $urandom | $urandom;
                    default: ready_bits = $urandom & $urandom;
                endcase
            end
            i_m_tready <= (holdoff_left == 0) && ready_bits[ready_phase];
        end
    end

    function automatic logic [PIX_W-1:0] make_pixel(input t_pix_mode mode);
        case (mode)
            PIX_ZERO:   return '0;
            PIX_SAT:    return '1;
            PIX_LOW:    return PIX_W'($urandom_range(0, 3));
            PIX_SPARSE: return ($urandom_range(0, 7) == 0) ? PIX_W'($urandom) : '0;
            default:    return PIX_W'($urandom);
        endcase
    endfunction

    function automatic t_pix_mode pick_mode();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return PIX_ZERO;
        if (r == 1)
            return PIX_SAT;
        if (r < 4)
            return PIX_LOW;
        if (r < 7)
            return PIX_SPARSE;
        return PIX_FULL;
    endfunction

    task automatic queue_pixels(input int count, input t_pix_mode mode, input bit steady);
        @(negedge i_clk);
        sender_steady = steady;
        repeat (count)
            pixel_q = {pixel_q, make_pixel(mode)};
    endtask

    task automatic queue_list(input logic [PIX_W-1:0] vals[$]);
        @(negedge i_clk);
        foreach (vals[k])
            pixel_q = {pixel_q, vals[k]};
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_IDX_WIDTH)
            width_reg = val;
        else
            height_reg = val;
    endtask

    // wait for all pixels taken and all centroids seen, then drain
    task automatic settle();
        while (pixel_q.size() != 0 || i_s_tvalid || centroid_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        int               random_items;
        int               area;
        int               windows;
        int               shape;
        logic [CFG_W-1:0] w_val;
        logic [CFG_W-1:0] h_val;
        bit               steady;
        logic [PIX_W-1:0] hot_last[$];

        random_items = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes: one saturated row at width 64, then one pixel per row to row 63
        queue_pixels(SIDE_MAX, PIX_SAT, 1'b0);
        settle();
        write_reg(CFG_IDX_WIDTH, 7'd1);
        queue_pixels(SIDE_MAX - 1, PIX_FULL, 1'b0);
        settle();

        // single pixel windows: empty, max, min
        write_reg(CFG_IDX_WIDTH, 7'd1);
        write_reg(CFG_IDX_HEIGHT, 7'd1);
        queue_list('{8'd0, 8'd255, 8'd1});
        settle();

        // rounding: tie to even below, above half, below half, empty
        write_reg(CFG_IDX_WIDTH, 7'd2);
        queue_list('{8'd1, 8'd1, 8'd1, 8'd3, 8'd3, 8'd1, 8'd0, 8'd0});
        settle();

        // tie on an odd quotient rounds up
        write_reg(CFG_IDX_WIDTH, 7'd4);
        queue_list('{8'd0, 8'd1, 8'd1, 8'd0});
        settle();

        // zero width taken as one and oversize height clamped to the maximum, then the other way round
        write_reg(CFG_IDX_WIDTH, 7'd0);
        write_reg(CFG_IDX_HEIGHT, 7'd127);
        hot_last = {};
        repeat (SIDE_MAX - 1) hot_last = {hot_last, 8'd0};
        hot_last = {hot_last, 8'd255};
        queue_list(hot_last);
        settle();
        write_reg(CFG_IDX_WIDTH, 7'd127);
        write_reg(CFG_IDX_HEIGHT, 7'd0);
        queue_list(hot_last);
        settle();

        // size change with a window half done
        write_reg(CFG_IDX_WIDTH, 7'd8);
        write_reg(CFG_IDX_HEIGHT, 7'd2);
        queue_pixels(6, PIX_FULL, 1'b0);
        settle();
        write_reg(CFG_IDX_WIDTH, 7'd3);
        queue_pixels(10, PIX_FULL, 1'b0);
        settle();
        write_reg(CFG_IDX_WIDTH, 7'd4);
        write_reg(CFG_IDX_HEIGHT, 7'd4);
        queue_pixels(5, PIX_FULL, 1'b0);
        settle();
        write_reg(CFG_IDX_WIDTH, 7'd2);
        write_reg(CFG_IDX_HEIGHT, 7'd2);
        queue_pixels(9, PIX_FULL, 1'b0);
        settle();

        // receiver holds off while small windows keep coming
        press_req++;
        queue_pixels(160, PIX_FULL, 1'b1);
        settle();

        // random phases
        while (random_items < RANDOM_ITEMS) begin
            shape = $urandom_range(0, 15);
            if (shape == 0) begin
                w_val = $urandom_range(0, 1) ? 7'd0 : CFG_W'($urandom_range(65, 127));
                h_val = CFG_W'($urandom_range(1, 3));
            end else if (shape == 1) begin
                w_val = CFG_W'($urandom_range(9, 64));
                h_val = CFG_W'($urandom_range(1, 4));
            end else if (shape == 2) begin
                w_val = CFG_W'($urandom_range(1, 4));
                h_val = $urandom_range(0, 1) ? CFG_W'($urandom_range(9, 64))
                                             : CFG_W'($urandom_range(65, 127));
            end else begin
                w_val = CFG_W'($urandom_range(1, 8));
                h_val = CFG_W'($urandom_range(1, 8));
            end
            if ($urandom_range(0, 5) != 0)
                write_reg(CFG_IDX_WIDTH, w_val);
            if ($urandom_range(0, 5) != 0)
                write_reg(CFG_IDX_HEIGHT, h_val);
            area    = side_of(width_reg) * side_of(height_reg);
            if (area > 256)
                area = side_of(width_reg);
            windows = $urandom_range(2, 8);
            steady  = ($urandom_range(0, 3) == 0);
            repeat (windows) begin
                queue_pixels(area, pick_mode(), steady);
                random_items += area;
            end
            if ($urandom_range(0, 3) == 0) begin
                area = $urandom_range(1, area);
                queue_pixels(area, pick_mode(), steady);
                random_items += area;
            end
            settle();
        end

        settle();
        if (error_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
